// ===== hdl/rqrc_pkg.sv =====
// Shared types and constants for the ring queue with reserve and commit.
package rqrc_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 64;

    localparam int CMD_W     = 3;
    localparam int PAYLOAD_W = 64;
    localparam int SLOT_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_RESERVE = 3'd1,
        CMD_COMMIT  = 3'd2,
        CMD_POP     = 3'd3,
        CMD_PEEK    = 3'd4,
        CMD_ADVANCE = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_READY = 2'd3
    } status_t;

endpackage

// ===== hdl/rqrc_if.sv =====
// Request and response channel interfaces of the ring queue.
interface rqrc_req_if
    import rqrc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [PAYLOAD_W-1:0] payload;
    logic [SLOT_W-1:0]    slot_index;

    modport source (output valid, output cmd, output payload, output slot_index, input ready);
    modport sink   (input valid, input cmd, input payload, input slot_index, output ready);
endinterface

interface rqrc_rsp_if
    import rqrc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] data_out;
    logic [SLOT_W-1:0]    slot_out;
    logic [OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output data_out, output slot_out,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input data_out, input slot_out,
                    input occupancy, output ready);
endinterface

// ===== hdl/rqrc_mem.sv =====
// Entry storage of the ring queue: one write port and one registered read port.
module rqrc_mem
    import rqrc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0]    rd_data
);

    logic [DATA_WIDTH-1:0] store_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ring_queue_reserve_commit.sv =====
// Top level of the ring queue with per-slot ready bits, reserve and commit.
//
// Requests arrive on the req channel as valid/ready beats carrying cmd, payload
// and slot_index. Each request gives exactly one response beat on the rsp
// channel with status, data_out, slot_out and occupancy.
// A request is captured into an input register, worked in one pass of logic
// against the queue state and written into a response register, from which
// the response beat is driven; one request is taken in every cycle while the
// responses are drained. The registered read of the entry memory is issued
// when a request is taken, at the read position that request will see; a
// write by the request ahead of it is forwarded.
// When the receiver stalls, the response register holds its beat, the request
// in the input register waits, and req.ready drops once both are full.
// Reset clears the counters, all ready bits and both valid flags. The entry
// memory is not cleared; an entry is read only after it has been written.
module ring_queue_reserve_commit
    import rqrc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rqrc_req_if.sink     req,
    rqrc_rsp_if.source   rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;

    logic                  stage_valid_reg;
    logic [CMD_W-1:0]      stage_cmd_reg;
    logic [DATA_WIDTH-1:0] stage_data_reg;
    logic [IDX_W-1:0]      stage_named_reg;
    logic                  fwd_valid_reg;
    logic [DATA_WIDTH-1:0] fwd_data_reg;
    logic [CNT_W-1:0]      wr_count_reg;
    logic [CNT_W-1:0]      rd_count_reg;
    logic [DEPTH-1:0]      ready_reg;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [PAYLOAD_W-1:0]  out_data_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [OCC_W-1:0]      out_occ_reg;

    logic [CNT_W-1:0]      wr_count_next;
    logic [CNT_W-1:0]      rd_count_next;
    logic [DEPTH-1:0]      ready_next;

    logic                  stage_fire;
    logic                  accept;
    logic [CNT_W-1:0]      level;
    logic [CNT_W-1:0]      level_after;
    logic                  full;
    logic                  empty;
    logic [IDX_W-1:0]      widx;
    logic [IDX_W-1:0]      ridx;
    logic [IDX_W+7:0]      named_wide;
    logic [IDX_W+7:0]      slot_wide;
    logic [CNT_W+8:0]      occ_wide;
    logic [DATA_WIDTH-1:0] mem_rd_data;
    logic [DATA_WIDTH-1:0] entry_data;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic                  set_en;
    logic [IDX_W-1:0]      set_addr;
    logic                  clr_en;
    logic                  wr_inc;
    logic                  rd_inc;
    logic                  slot_hit;
    logic                  data_hit;
    status_t               status;
    logic                  fwd_hit;

    assign stage_fire = stage_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !stage_valid_reg || stage_fire;
    assign accept     = req.valid && req.ready;

    assign level = wr_count_reg - rd_count_reg;
    assign full  = level[CNT_W-1];
    assign empty = (level == '0);
    assign widx  = wr_count_reg[IDX_W-1:0];
    assign ridx  = rd_count_reg[IDX_W-1:0];

    assign named_wide = {{IDX_W{1'b0}}, req.slot_index};
    assign entry_data = fwd_valid_reg ? fwd_data_reg : mem_rd_data;

    always_comb
    begin
        status    = ST_OK;
        mem_we    = 1'b0;
        mem_waddr = widx;
        set_en    = 1'b0;
        set_addr  = widx;
        clr_en    = 1'b0;
        wr_inc    = 1'b0;
        rd_inc    = 1'b0;
        slot_hit  = 1'b0;
        data_hit  = 1'b0;
        case (stage_cmd_reg)
            CMD_PUSH:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    mem_we   = 1'b1;
                    set_en   = 1'b1;
                    slot_hit = 1'b1;
                    wr_inc   = 1'b1;
                end
            end
            CMD_RESERVE:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    slot_hit = 1'b1;
                    wr_inc   = 1'b1;
                end
            end
            CMD_COMMIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = stage_named_reg;
                set_en    = 1'b1;
                set_addr  = stage_named_reg;
            end
            CMD_POP, CMD_PEEK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (!ready_reg[ridx])
                begin
                    status = ST_NOT_READY;
                end
                else
                begin
                    data_hit = 1'b1;
                    if (stage_cmd_reg == CMD_POP)
                    begin
                        clr_en = 1'b1;
                        rd_inc = 1'b1;
                    end
                end
            end
            CMD_ADVANCE:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    clr_en = 1'b1;
                    rd_inc = 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // A reserve clears the ready bit of the slot it grants.
    always_comb
    begin
        wr_count_next = wr_count_reg;
        rd_count_next = rd_count_reg;
        ready_next    = ready_reg;
        if (stage_fire)
        begin
            wr_count_next = wr_count_reg + CNT_W'(wr_inc);
            rd_count_next = rd_count_reg + CNT_W'(rd_inc);
            if (stage_cmd_reg == CMD_RESERVE && wr_inc)
            begin
                ready_next[widx] = 1'b0;
            end
            if (set_en)
            begin
                ready_next[set_addr] = 1'b1;
            end
            if (clr_en)
            begin
                ready_next[ridx] = 1'b0;
            end
        end
    end

    assign level_after = wr_count_next - rd_count_next;
    assign slot_wide   = {8'd0, widx};
    assign occ_wide    = {9'd0, level_after};
    assign fwd_hit     = stage_fire && mem_we && (mem_waddr == rd_count_next[IDX_W-1:0]);

    rqrc_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (stage_fire && mem_we),
        .wr_addr (mem_waddr),
        .wr_data (stage_data_reg),
        .rd_en   (accept),
        .rd_addr (rd_count_next[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            wr_count_reg    <= '0;
            rd_count_reg    <= '0;
            ready_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            wr_count_reg <= wr_count_next;
            rd_count_reg <= rd_count_next;
            ready_reg    <= ready_next;
            if (req.ready)
            begin
                stage_valid_reg <= req.valid;
            end
            if (accept)
            begin
                fwd_valid_reg <= fwd_hit;
            end
            if (stage_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_cmd_reg   <= req.cmd;
            stage_data_reg  <= req.payload[DATA_WIDTH-1:0];
            stage_named_reg <= named_wide[IDX_W-1:0];
            fwd_data_reg    <= stage_data_reg;
        end
        if (stage_fire)
        begin
            out_status_reg <= status;
            out_data_reg   <= data_hit ? PAYLOAD_W'(entry_data) : '0;
            out_slot_reg   <= slot_hit ? slot_wide[SLOT_W-1:0] : '0;
            out_occ_reg    <= occ_wide[OCC_W-1:0];
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.data_out  = out_data_reg;
    assign rsp.slot_out  = out_slot_reg;
    assign rsp.occupancy = out_occ_reg;

endmodule

// ===== tb/sv/tb_ring_queue_reserve_commit.sv =====
// Self-checking testbench for the ring queue with per-slot ready bits, reserve and commit.
`timescale 1ns / 100ps

module tb_ring_queue_reserve_commit;
    import rqrc_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 200000;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam logic [OCC_W-1:0] FULL_LEVEL   = OCC_W'(DEPTH);

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [PAYLOAD_W-1:0] payload;
        logic [SLOT_W-1:0]    slot;
        logic                 aim;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [PAYLOAD_W-1:0] data;
        logic [SLOT_W-1:0]    slot;
        logic [OCC_W-1:0]     occ;
    } rsp_t;

    logic clk;
    logic rst_n;

    rqrc_req_if req_ch ();
    rqrc_rsp_if rsp_ch ();

    ring_queue_reserve_commit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    item_t pending [$];
    rsp_t  due_rsp [$];
    item_t on_bus;

    logic [PAYLOAD_W-1:0] slot_data [DEPTH];
    bit                   slot_rdy  [DEPTH];
    logic [OCC_W-1:0]     wr_pos = '0;
    logic [OCC_W-1:0]     rd_pos = '0;

    int queued         = 0;
    int accepted       = 0;
    int err_cnt        = 0;
    int cycle_cnt      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_arm     = 1'b0;
    bit   hold_used;
    int   hold_left;

    function automatic rsp_t ring_predict(item_t it);
        rsp_t             r;
        logic [OCC_W-1:0]  level;
        logic [SLOT_W-1:0] widx;
        logic [SLOT_W-1:0] ridx;
        r     = '0;
        level = wr_pos - rd_pos;
        widx  = wr_pos[SLOT_W-1:0];
        ridx  = rd_pos[SLOT_W-1:0];
        case (it.cmd)
            CMD_PUSH, CMD_RESERVE:
            begin
                if (level >= FULL_LEVEL)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    if (it.cmd == CMD_PUSH)
                    begin
                        slot_data[widx] = it.payload;
                        slot_rdy[widx]  = 1'b1;
                    end
                    else
                    begin
                        slot_rdy[widx] = 1'b0;
                    end
                    r.slot = widx;
                    wr_pos = wr_pos + 1'b1;
                end
            end
            CMD_COMMIT:
            begin
                slot_data[it.slot] = it.payload;
                slot_rdy[it.slot]  = 1'b1;
            end
            CMD_POP, CMD_PEEK:
            begin
                if (level == '0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (!slot_rdy[ridx])
                begin
                    r.status = ST_NOT_READY;
                end
                else
                begin
                    r.data = slot_data[ridx];
                    if (it.cmd == CMD_POP)
                    begin
                        slot_rdy[ridx] = 1'b0;
                        rd_pos = rd_pos + 1'b1;
                    end
                end
            end
            CMD_ADVANCE:
            begin
                if (level == '0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    slot_rdy[ridx] = 1'b0;
                    rd_pos = rd_pos + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.occ = wr_pos - rd_pos;
        return r;
    endfunction

    // An aimed commit picks an allocated, not ready slot, or keeps its own if none is open.
    function automatic logic [SLOT_W-1:0] open_slot(logic [SLOT_W-1:0] fallback);
        logic [SLOT_W-1:0] found [$];
        logic [OCC_W-1:0]  level;
        logic [SLOT_W-1:0] idx;
        level = wr_pos - rd_pos;
        for (int k = 0; k < level; k++)
        begin
            idx = rd_pos[SLOT_W-1:0] + SLOT_W'(k);
            if (!slot_rdy[idx])
                found.push_back(idx);
        end
        if (found.size() == 0)
            return fallback;
        if ($urandom_range(1) != 0)
            return found[0];
        return found[$urandom_range(found.size() - 1)];
    endfunction

    function void field_chk(string what, logic [63:0] want, logic [63:0] seen);
        if (want !== seen)
        begin
            err_cnt++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, seen);
        end
    endfunction

    function void add_item(logic [CMD_W-1:0] cmd, logic [PAYLOAD_W-1:0] payload,
                           logic [SLOT_W-1:0] slot);
        item_t it;
        it.cmd     = cmd;
        it.payload = payload;
        it.slot    = slot;
        it.aim     = 1'b0;
        pending.push_back(it);
        queued++;
    endfunction

    task automatic add_random(int n, int w_push, int w_res, int w_com, int w_pop,
                              int w_peek, int w_adv);
        item_t it;
        int    pick;
        int    total;
        total = w_push + w_res + w_com + w_pop + w_peek + w_adv;
        repeat (n)
        begin
            pick = $urandom_range(total - 1);
            if ($urandom_range(99) < 3)
                it.cmd = ($urandom_range(1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
            else if (pick < w_push)
                it.cmd = CMD_PUSH;
            else if (pick < w_push + w_res)
                it.cmd = CMD_RESERVE;
            else if (pick < w_push + w_res + w_com)
                it.cmd = CMD_COMMIT;
            else if (pick < w_push + w_res + w_com + w_pop)
                it.cmd = CMD_POP;
            else if (pick < total - w_adv)
                it.cmd = CMD_PEEK;
            else
                it.cmd = CMD_ADVANCE;
            case ($urandom_range(9))
                0: it.payload = '0;
                1: it.payload = '1;
                default: it.payload = {$urandom, $urandom};
            endcase
            it.slot = SLOT_W'($urandom_range(DEPTH - 1));
            it.aim  = (it.cmd == CMD_COMMIT) && ($urandom_range(99) < 85);
            pending.push_back(it);
            queued++;
        end
    endtask

    task automatic pace(int send_pct, int stall_pct);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic drain();
        while (accepted != queued || due_rsp.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Request driver; the expected response is worked out when the beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.cmd        <= '0;
            req_ch.payload    <= '0;
            req_ch.slot_index <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                due_rsp.push_back(ring_predict(on_bus));
                accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = pending.pop_front();
                    if (on_bus.aim)
                        on_bus.slot = open_slot(on_bus.slot);
                    req_ch.valid      <= 1'b1;
                    req_ch.cmd        <= on_bus.cmd;
                    req_ch.payload    <= on_bus.payload;
                    req_ch.slot_index <= on_bus.slot;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_arm && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_rsp.size() == 0)
            begin
                err_cnt++;
                $display("%0t: response beat with none expected, actual status %0d",
                         $time, rsp_ch.status);
            end
            else
            begin
                field_chk("status", 64'(due_rsp[0].status), 64'(rsp_ch.status));
                field_chk("data_out", due_rsp[0].data, rsp_ch.data_out);
                field_chk("slot_out", 64'(due_rsp[0].slot), 64'(rsp_ch.slot_out));
                field_chk("occupancy", 64'(due_rsp[0].occ), 64'(rsp_ch.occupancy));
                void'(due_rsp.pop_front());
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = '0;
        req_ch.payload    = '0;
        req_ch.slot_index = '0;
        rsp_ch.ready      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pace(0, 0);
        add_item(CMD_POP,      64'h0, 8'h00);
        add_item(CMD_PEEK,     64'h0, 8'hFF);
        add_item(CMD_ADVANCE,  64'h0, 8'h00);
        add_item(CMD_PUSH,     64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        add_item(CMD_PEEK,     64'h0, 8'h00);
        add_item(CMD_POP,      64'h0, 8'h00);
        add_item(CMD_PUSH,     64'h0, 8'h00);
        add_item(CMD_RESERVE,  64'h1234_5678_9ABC_DEF0, 8'h00);
        add_item(CMD_POP,      64'h0, 8'h00);
        add_item(CMD_PEEK,     64'h0, 8'h00);
        add_item(CMD_POP,      64'h0, 8'h00);
        add_item(CMD_COMMIT,   64'hA5A5_A5A5_5A5A_5A5A, 8'h02);
        add_item(CMD_POP,      64'h0, 8'h00);
        add_item(CMD_RESERVE,  64'h0, 8'h00);
        add_item(CMD_ADVANCE,  64'h0, 8'h00);
        add_item(CMD_COMMIT,   64'h0123_4567_89AB_CDEF, 8'hFF);
        add_item(CMD_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        add_item(CMD_SPARE_HI, 64'h0, 8'h00);
        add_item(CMD_PUSH,     64'h5A5A_0000_FFFF_C3C3, 8'hFF);
        add_item(CMD_COMMIT,   64'h8000_0000_0000_0001, 8'h00);
        add_item(CMD_POP,      64'h0, 8'h00);
        add_item(CMD_PUSH,     64'h0F0F_0F0F_0F0F_0F0F, 8'h00);
        add_item(CMD_COMMIT,   64'hF0F0_F0F0_F0F0_F0F0, 8'h05);
        add_item(CMD_POP,      64'h0, 8'h00);
        drain();

        add_random(320, 65, 25, 6, 1, 2, 1);
        drain();

        pace(78, 0);
        add_random(200, 5, 3, 12, 50, 5, 25);
        drain();

        pace(0, 78);
        hold_arm = 1'b1;
        add_random(120, 30, 15, 15, 25, 8, 7);
        drain();

        pace(21, 21);
        add_random(140, 5, 3, 12, 50, 5, 25);
        drain();

        pace(0, 0);
        add_random(120, 25, 10, 15, 30, 10, 10);
        drain();

        repeat (8) @(posedge clk);
        if (err_cnt == 0 && due_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rqrc_pkg.sv
hdl/rqrc_if.sv
hdl/rqrc_mem.sv
hdl/ring_queue_reserve_commit.sv
tb/sv/tb_ring_queue_reserve_commit.sv
